/* design/iil_pkg.sv */
// Package for the indexed insert list.
// Holds the request and status codes and the per-cell operation struct.
// No dependencies.
package iil_pkg;

    // Request codes carried on the mode field.
    typedef enum logic [1:0] {
        MODE_INSERT  = 2'd0,
        MODE_POP     = 2'd1,
        MODE_OBSERVE = 2'd2
    } mode_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_BAD  = 2'd1,
        STATUS_FULL = 2'd2
    } status_t;

    // Operation broadcast to every cell for the accepted transaction.
    typedef struct packed {
        logic insert_go;
        logic pop_go;
    } cell_op_t;

endpackage

/* design/indexed_insert_list.sv */
// Top level of the indexed insert list: control, cell chain and output register.
// Depends on iil_pkg and iil_cell.
//
// An ordered list of up to CAPACITY words held in a chain of cells, entry n in
// cell n. Each transaction is an insert at a position, a pop from the front or
// an observe at a position, and gives exactly one result carrying the word (for
// pop and observe), a status and the entry count after the operation. A
// request is handled by every cell in parallel, each deciding whether to load,
// shift or hold, and the result is captured in the output register at the same
// edge. One transaction is accepted per cycle as long as the result register is
// empty or being drained in that cycle; a stalled result holds off new input.
// Reset empties the list; cell contents are not cleared.
module indexed_insert_list #(
    parameter int CAPACITY  = 16,
    parameter int WORD_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [4:0]  position,
    input  logic [31:0] data_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] data_out,
    output logic [1:0]  status,
    output logic [4:0]  entry_count
);
    import iil_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 5) ? CW : 5;
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    logic                 in_fire;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [31:0]          data_out_reg;
    logic [31:0]          data_out_next;
    status_t              status_reg;
    status_t              status_next;
    logic [4:0]           entry_count_reg;
    logic [4:0]           entry_count_next;
    cell_op_t             op;
    logic [PW-1:0]        pos_ext;
    logic [PW-1:0]        count_ext;
    logic [WORD_BITS-1:0] load_word;
    logic [WORD_BITS-1:0] cell_word [CAPACITY];
    logic [WORD_BITS-1:0] cell_read [CAPACITY];
    logic [WORD_BITS-1:0] read_bus;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign pos_ext   = PW'(position);
    assign count_ext = PW'(count_reg);
    assign load_word = WORD_BITS'(data_in);

    // Request decode, result and count update.
    always_comb
    begin
        op               = '0;
        count_next       = count_reg;
        data_out_next    = data_out_reg;
        status_next      = status_reg;
        entry_count_next = entry_count_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        if (in_fire) begin
            out_valid_next = 1'b1;
            data_out_next  = '0;
            status_next    = STATUS_BAD;
            case (mode_t'(mode))
                MODE_INSERT:
                begin
                    if (pos_ext > count_ext) begin
                        status_next = STATUS_BAD;
                    end else if (count_reg >= CAP) begin
                        status_next = STATUS_FULL;
                    end else begin
                        op.insert_go = 1'b1;
                        count_next   = count_reg + CW'(1);
                        status_next  = STATUS_OK;
                    end
                end
                MODE_POP:
                begin
                    if (count_reg != '0) begin
                        op.pop_go     = 1'b1;
                        count_next    = count_reg - CW'(1);
                        data_out_next = 32'(cell_word[0]);
                        status_next   = STATUS_OK;
                    end
                end
                MODE_OBSERVE:
                begin
                    if (pos_ext < count_ext) begin
                        data_out_next = 32'(read_bus);
                        status_next   = STATUS_OK;
                    end
                end
                default:
                begin
                    status_next = STATUS_BAD;
                end
            endcase
            entry_count_next = 5'(count_next);
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        data_out_reg    <= data_out_next;
        status_reg      <= status_next;
        entry_count_reg <= entry_count_next;
    end

    // The chain of cells; each takes its neighbours' words.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [WORD_BITS-1:0] left_word;
        logic [WORD_BITS-1:0] right_word;

        if (i == 0) begin : g_first
            assign left_word = load_word;
        end else begin : g_mid
            assign left_word = cell_word[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_word = '0;
        end else begin : g_inner
            assign right_word = cell_word[i+1];
        end

        iil_cell #(
            .INDEX     (i),
            .WORD_BITS (WORD_BITS),
            .PW        (PW)
        ) u_cell (
            .clk        (clk),
            .op         (op),
            .pos        (pos_ext),
            .count      (count_ext),
            .load_word  (load_word),
            .left_word  (left_word),
            .right_word (right_word),
            .word       (cell_word[i]),
            .read_word  (cell_read[i])
        );
    end

    // Combine the read bus; at most one cell drives a non-zero word.
    always_comb
    begin
        read_bus = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            read_bus = read_bus | cell_read[k];
        end
    end

    assign out_valid   = out_valid_reg;
    assign data_out    = data_out_reg;
    assign status      = status_reg;
    assign entry_count = entry_count_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP)
        else $error("entry count exceeds capacity");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        op.insert_go |=> count_reg == $past(count_reg) + CW'(1))
        else $error("successful insert did not add one entry");

    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        op.pop_go |=> count_reg == $past(count_reg) - CW'(1))
        else $error("successful pop did not remove one entry");

    a_full_only_at_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (status_next == STATUS_FULL)) |-> (count_reg == CAP))
        else $error("full status reported below capacity");

    a_error_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != STATUS_OK)) |-> (data_out_reg == '0))
        else $error("error result carries non-zero data");
`endif

endmodule

/* design/iil_cell.sv */
// One storage cell of the indexed insert list chain.
// Depends on iil_pkg for the broadcast operation struct.
module iil_cell #(
    parameter int INDEX     = 0,
    parameter int WORD_BITS = 32,
    parameter int PW        = 5
) (
    input  logic                   clk,
    input  iil_pkg::cell_op_t      op,
    input  logic [PW-1:0]          pos,
    input  logic [PW-1:0]          count,
    input  logic [WORD_BITS-1:0]   load_word,
    input  logic [WORD_BITS-1:0]   left_word,
    input  logic [WORD_BITS-1:0]   right_word,
    output logic [WORD_BITS-1:0]   word,
    output logic [WORD_BITS-1:0]   read_word
);
    import iil_pkg::*;

    localparam logic [PW-1:0] IDX      = PW'(INDEX);
    localparam logic [PW-1:0] NEXT_IDX = PW'(INDEX + 1);

    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;

    // Local decision: load, take from the front neighbour, take from the
    // back neighbour, or hold.
    always_comb
    begin
        word_next = word_reg;
        if (op.insert_go) begin
            if (IDX == pos) begin
                word_next = load_word;
            end else if ((IDX > pos) && (IDX <= count)) begin
                word_next = left_word;
            end
        end else if (op.pop_go) begin
            if (NEXT_IDX < count) begin
                word_next = right_word;
            end
        end
    end

    // Payload register, no reset needed.
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word      = word_reg;
    // Drive the shared read bus only when this cell is addressed.
    assign read_word = (IDX == pos) ? word_reg : '0;

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the indexed insert list.
// Depends on iil_pkg and the indexed_insert_list RTL; it holds its own model of
// the list contents and count and checks every result transaction against it.
module testbench;

    import iil_pkg::*;

    localparam int CAPACITY       = 16;
    localparam int WORD_BITS      = 32;
    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_REPORTS    = 10;
    localparam int SETTLE_CYCLES  = 10;

    // The fourth mode encoding has no operation behind it.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // One expected result: word returned, status and entry count afterwards.
    typedef struct packed {
        logic [31:0] word;
        status_t     st;
        logic [4:0]  count;
    } list_reply_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [1:0]  mode        = MODE_INSERT;
    logic [4:0]  position    = '0;
    logic [31:0] data_in     = '0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [31:0] data_out;
    logic [1:0]  status;
    logic [4:0]  entry_count;

    // Model of the list in entry order, and the replies still to arrive.
    logic [31:0] list_words[$];
    list_reply_t pending_replies[$];

    int mismatch_count   = 0;
    int quiet_cycles     = 0;
    int sink_stall_left  = 0;
    bit sender_gaps_on   = 1'b0;
    bit sink_stalls_on   = 1'b0;

    indexed_insert_list #(
        .CAPACITY  (CAPACITY),
        .WORD_BITS (WORD_BITS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .position    (position),
        .data_in     (data_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .data_out    (data_out),
        .status      (status),
        .entry_count (entry_count)
    );

    always #CLK_HALF clk = ~clk;

    // Apply one request to the list model and return the reply it should give.
    function automatic list_reply_t apply_list_request(logic [1:0] op, logic [4:0] pos,
                                                       logic [31:0] word);
        list_reply_t reply;
        int          n;
        n          = list_words.size();
        reply.word = '0;
        reply.st   = STATUS_BAD;
        case (op)
            MODE_INSERT:
            begin
                // The position check takes precedence over the full check.
                if (pos > n)
                    reply.st = STATUS_BAD;
                else if (n >= CAPACITY)
                    reply.st = STATUS_FULL;
                else
                begin
                    list_words.insert(pos, word);
                    reply.st = STATUS_OK;
                end
            end
            MODE_POP:
            begin
                if (n != 0)
                begin
                    reply.word = list_words.pop_front();
                    reply.st   = STATUS_OK;
                end
            end
            MODE_OBSERVE:
            begin
                if (pos < n)
                begin
                    reply.word = list_words[pos];
                    reply.st   = STATUS_OK;
                end
            end
            default:
            begin
                reply.st = STATUS_BAD;
            end
        endcase
        reply.count = 5'(list_words.size());
        return reply;
    endfunction

    task automatic report_mismatch(string what, list_reply_t want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display({"%0t: %s: expected data %h status %0d count %0d, ",
                      "got data %h status %0d count %0d"},
                     $realtime, what, want.word, want.st, want.count,
                     data_out, status, entry_count);
    endtask

    // Send one request transaction, with an optional gap before it. Entered and
    // left just after a falling edge; valid is left high for the next request.
    task automatic send_request(logic [1:0] op, logic [4:0] pos, logic [31:0] word);
        int gap;
        if (sender_gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap      = $urandom_range(1, 10);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        mode     = op;
        position = pos;
        data_in  = word;
        forever
        begin
            @(posedge clk);
            if (in_ready)
                break;
        end
        pending_replies.push_back(apply_list_request(op, pos, word));
        @(negedge clk);
    endtask

    // Stop sending and wait until every expected result has been seen.
    task automatic hold_until_results_drained();
        in_valid = 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Requests on an empty list, all of which should fail or change nothing.
    task automatic test_empty_list();
        send_request(MODE_POP, 5'd0, 32'h1234_5678);
        send_request(MODE_OBSERVE, 5'd0, 32'h0);
        send_request(MODE_OBSERVE, 5'd31, 32'h0);
        send_request(MODE_INSERT, 5'd1, 32'hDEAD_BEEF);
        send_request(MODE_UNUSED, 5'd0, 32'hFFFF_FFFF);
    endtask

    // Fill the list, inserting at the end, the front and the middle in turn.
    task automatic test_fill_to_capacity();
        logic [31:0] patterns[6];
        int          n;
        patterns = '{32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                     32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0000};
        for (int i = 0; i < CAPACITY; i++)
        begin
            n = list_words.size();
            case (i % 3)
                0:       send_request(MODE_INSERT, 5'(n), patterns[i % 6]);
                1:       send_request(MODE_INSERT, 5'd0, patterns[i % 6]);
                default: send_request(MODE_INSERT, 5'(n / 2), $urandom);
            endcase
        end
    endtask

    // Inserts against a full list, and reads at its far end.
    task automatic test_full_list();
        send_request(MODE_INSERT, 5'd16, 32'h0BAD_F00D);
        send_request(MODE_INSERT, 5'd0, 32'h0BAD_F00D);
        send_request(MODE_INSERT, 5'd17, 32'h0BAD_F00D);
        send_request(MODE_INSERT, 5'd31, 32'h0BAD_F00D);
        send_request(MODE_OBSERVE, 5'd15, 32'h0);
        send_request(MODE_OBSERVE, 5'd16, 32'h0);
    endtask

    // Mostly well-formed traffic that swings the list between empty and full,
    // with some out-of-range positions and unused modes mixed in.
    task automatic test_random_traffic(int n_items, bit allow_idling);
        int          fill_bias;
        int          pick;
        int          n;
        logic [1:0]  op;
        logic [4:0]  pos;
        logic [31:0] word;
        fill_bias = 50;
        for (int i = 0; i < n_items; i++)
        begin
            // Every so often change the direction of drift and the idling.
            if (i % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       fill_bias = 85;
                    1:       fill_bias = 15;
                    default: fill_bias = 50;
                endcase
                sender_gaps_on = allow_idling && ($urandom_range(0, 3) != 0);
                sink_stalls_on = allow_idling && ($urandom_range(0, 3) != 0);
            end
            n    = list_words.size();
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 7))
                0:       word = 32'h0;
                1:       word = 32'hFFFF_FFFF;
                default: word = $urandom;
            endcase
            if (pick < 6)
            begin
                op  = 2'($urandom_range(0, 3));
                pos = 5'($urandom);
            end
            else if (pick < 36)
            begin
                op = MODE_OBSERVE;
                if (n > 0 && $urandom_range(0, 9) != 0)
                    pos = 5'($urandom_range(0, n - 1));
                else
                    pos = 5'($urandom);
            end
            else if ($urandom_range(0, 99) < fill_bias)
            begin
                op = MODE_INSERT;
                if ($urandom_range(0, 9) != 0)
                    pos = 5'($urandom_range(0, n));
                else
                    pos = 5'($urandom);
            end
            else
            begin
                op  = MODE_POP;
                pos = 5'($urandom);
            end
            send_request(op, pos, word);
        end
    endtask

    // Check every result transaction against the oldest expected reply.
    always @(posedge clk)
    begin
        list_reply_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_replies.size() == 0)
            begin
                want = '0;
                report_mismatch("result with none expected", want);
            end
            else
            begin
                want = pending_replies.pop_front();
                if (data_out !== want.word || status !== want.st ||
                    entry_count !== want.count)
                    report_mismatch("result mismatch", want);
            end
        end
    end

    // Result side back-pressure in random bursts; none at all once stalls are off.
    always @(negedge clk)
    begin
        if (!sink_stalls_on)
        begin
            sink_stall_left = 0;
            out_ready <= 1'b1;
        end
        else if (sink_stall_left > 0)
        begin
            sink_stall_left--;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            sink_stall_left = $urandom_range(1, 10) - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Watchdog: end the run if no transaction moves on either side for too long.
    initial
    begin
        @(posedge rst_n);
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Test sequence.
    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n          = 1'b1;
        sender_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;

        test_empty_list();
        test_fill_to_capacity();
        test_full_list();
        hold_until_results_drained();

        test_random_traffic(300, 1'b1);
        hold_until_results_drained();
        test_random_traffic(300, 1'b1);

        // The last stretch runs at full rate with no idling on either side.
        sender_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
        test_random_traffic(100, 1'b0);
        hold_until_results_drained();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_replies.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
